[src/accel_tilt_gauge_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the tilt gauge unit
// Clocked implication checks, reset masked.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_GAUGE_UNIT_ASSERT_SVH
`define ACCEL_TILT_GAUGE_UNIT_ASSERT_SVH

// same-cycle implication
`define ATG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tilt gauge assertion failed");

// next-cycle implication
`define ATG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tilt gauge assertion failed");

`endif

[src/atg_pkg.sv]
// ---------------------------------------------------------------------------
// atg_pkg
// Constants, types and the arctangent table shared by the tilt gauge unit.
// ---------------------------------------------------------------------------
package atg_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;

    localparam int MAG_W      = SAMPLE_BITS;
    localparam int DATA_W     = SAMPLE_BITS + 24;
    localparam int ANG_W      = 25;
    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W = 5;
    localparam int GAIN_W     = 17;
    localparam int GAUGE_W    = 7;

    localparam logic [GAIN_W-1:0]  GAIN_Q16  = GAIN_W'(107922);
    localparam logic [GAUGE_W-1:0] GAUGE_MAX = GAUGE_W'(100);
    localparam logic [GAUGE_W-1:0] DEMO_STEP = GAUGE_W'(2);

    // gauge = floor(angle * 20 / (9 * 2^16)); saturates at this angle
    localparam int SCALED_W  = 26;
    localparam int QIN_W     = 10;
    localparam int RECIP_W   = 13;
    localparam int PROD_W    = QIN_W + RECIP_W;
    localparam logic [ANG_W-2:0]   SAT_ANGLE = (ANG_W-1)'(2949120);
    localparam logic [SCALED_W-1:0] TILT_NUM = SCALED_W'(20);
    localparam logic [RECIP_W-1:0] RECIP_9   = RECIP_W'(7282);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PASS1  = 5'b00010,
        ST_PASS2  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_TILT = 2'd1,
        OP_DEMO = 2'd2
    } commit_op_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       start_pass2;
        logic       finish;
        logic       commit;
        commit_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic step_last;
    } dp_status_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic [ANG_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = ANG_W'(2949120);
            5'd1:    v = ANG_W'(1740967);
            5'd2:    v = ANG_W'(919879);
            5'd3:    v = ANG_W'(466945);
            5'd4:    v = ANG_W'(234379);
            5'd5:    v = ANG_W'(117304);
            5'd6:    v = ANG_W'(58666);
            5'd7:    v = ANG_W'(29335);
            5'd8:    v = ANG_W'(14668);
            5'd9:    v = ANG_W'(7334);
            5'd10:   v = ANG_W'(3667);
            5'd11:   v = ANG_W'(1833);
            5'd12:   v = ANG_W'(917);
            5'd13:   v = ANG_W'(458);
            5'd14:   v = ANG_W'(229);
            5'd15:   v = ANG_W'(115);
            5'd16:   v = ANG_W'(57);
            5'd17:   v = ANG_W'(29);
            5'd18:   v = ANG_W'(14);
            5'd19:   v = ANG_W'(7);
            5'd20:   v = ANG_W'(4);
            5'd21:   v = ANG_W'(2);
            5'd22:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/atg_datapath.sv]
// ---------------------------------------------------------------------------
// atg_datapath
// Shared CORDIC vectoring unit, angle-to-gauge scaling and the gauge register.
// ---------------------------------------------------------------------------
module atg_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_x,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_y,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_z,
    input  atg_pkg::dp_cmd_t                   cmd,
    output atg_pkg::dp_status_t                status,
    output logic [atg_pkg::GAUGE_W-1:0]        m_gauge_percent
);

    logic signed [atg_pkg::DATA_W-1:0]  x_reg, x_next;
    logic signed [atg_pkg::DATA_W-1:0]  y_reg, y_next;
    logic signed [atg_pkg::ANG_W-1:0]   angle_reg, angle_next;
    logic [atg_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [atg_pkg::MAG_W-1:0]          ax_mag_reg, ax_mag_next;
    logic                               zero_reg, zero_next;
    logic [atg_pkg::GAUGE_W-1:0]        tilt_reg, tilt_next;
    logic [atg_pkg::GAUGE_W-1:0]        gauge_reg, gauge_next;

    logic [atg_pkg::MAG_W-1:0]          ax_mag, ay_mag, az_mag;
    logic signed [atg_pkg::DATA_W-1:0]  dx, dy, x_step, y_step;
    logic signed [atg_pkg::ANG_W-1:0]   atan_val, angle_step;
    logic                               rot_cw;
    logic [atg_pkg::MAG_W+atg_pkg::GAIN_W-1:0] ax_gain;
    logic [atg_pkg::ANG_W-2:0]          angle_mag;
    logic [atg_pkg::SCALED_W-1:0]       scaled;
    logic [atg_pkg::QIN_W-1:0]          qin;
    logic [atg_pkg::PROD_W-1:0]         qprod;
    logic [atg_pkg::GAUGE_W-1:0]        tilt_val;
    logic [atg_pkg::GAUGE_W-1:0]        demo_val;

    // magnitudes; the most negative sample maps to 2^(SAMPLE_BITS-1)
    always_comb begin
        ax_mag = s_accel_x[atg_pkg::SAMPLE_BITS-1] ? atg_pkg::MAG_W'(-s_accel_x)
                                                    : atg_pkg::MAG_W'(s_accel_x);
        ay_mag = s_accel_y[atg_pkg::SAMPLE_BITS-1] ? atg_pkg::MAG_W'(-s_accel_y)
                                                    : atg_pkg::MAG_W'(s_accel_y);
        az_mag = s_accel_z[atg_pkg::SAMPLE_BITS-1] ? atg_pkg::MAG_W'(-s_accel_z)
                                                    : atg_pkg::MAG_W'(s_accel_z);
    end

    // one CORDIC micro-rotation, floor shifts
    always_comb begin
        dx       = y_reg >>> step_reg;
        dy       = x_reg >>> step_reg;
        rot_cw   = !y_reg[atg_pkg::DATA_W-1];
        atan_val = $signed(atg_pkg::atan_q16(atg_pkg::ATAN_IDX_W'(step_reg)));
        if (rot_cw) begin
            x_step     = x_reg + dx;
            y_step     = y_reg - dy;
            angle_step = angle_reg + atan_val;
        end else begin
            x_step     = x_reg - dx;
            y_step     = y_reg + dy;
            angle_step = angle_reg - atan_val;
        end
    end

    assign ax_gain = ax_mag_reg * atg_pkg::GAIN_Q16;
    assign status.step_last = (step_reg == atg_pkg::STEP_W'(atg_pkg::CORDIC_STEPS - 1));

    // angle (Q16 degrees) to gauge; negative angle counts as zero
    always_comb begin
        angle_mag = angle_reg[atg_pkg::ANG_W-1] ? '0 : angle_reg[atg_pkg::ANG_W-2:0];
        scaled    = atg_pkg::SCALED_W'(angle_mag) * atg_pkg::TILT_NUM;
        qin       = scaled[atg_pkg::SCALED_W-1 -: atg_pkg::QIN_W];
        qprod     = atg_pkg::PROD_W'(qin) * atg_pkg::PROD_W'(atg_pkg::RECIP_9);
        if (zero_reg) begin
            tilt_val = '0;
        end else if (angle_mag >= atg_pkg::SAT_ANGLE) begin
            tilt_val = atg_pkg::GAUGE_MAX;
        end else begin
            tilt_val = qprod[atg_pkg::PROD_W-1 -: atg_pkg::GAUGE_W];
        end
    end

    always_comb begin
        demo_val = gauge_reg + atg_pkg::DEMO_STEP;
        if (demo_val > atg_pkg::GAUGE_MAX) begin
            demo_val = '0;
        end
    end

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        angle_next  = angle_reg;
        step_next   = step_reg;
        ax_mag_next = ax_mag_reg;
        zero_next   = zero_reg;
        tilt_next   = tilt_reg;
        gauge_next  = gauge_reg;

        if (cmd.load) begin
            x_next      = $signed(atg_pkg::DATA_W'(ay_mag) << atg_pkg::FRAC_BITS);
            y_next      = $signed(atg_pkg::DATA_W'(az_mag) << atg_pkg::FRAC_BITS);
            angle_next  = '0;
            step_next   = '0;
            ax_mag_next = ax_mag;
            zero_next   = (ax_mag == '0) && (ay_mag == '0) && (az_mag == '0);
        end else if (cmd.start_pass2) begin
            // second pass vectors (G*r, |ax|*G)
            x_next     = x_step;
            y_next     = $signed(atg_pkg::DATA_W'(ax_gain));
            angle_next = '0;
            step_next  = '0;
        end else if (cmd.step) begin
            x_next     = x_step;
            y_next     = y_step;
            angle_next = angle_step;
            step_next  = step_reg + 1'b1;
        end

        if (cmd.finish) begin
            tilt_next = tilt_val;
        end

        if (cmd.commit) begin
            unique case (cmd.op)
                atg_pkg::OP_TILT: gauge_next = tilt_reg;
                atg_pkg::OP_DEMO: gauge_next = demo_val;
                atg_pkg::OP_HOLD: gauge_next = gauge_reg;
                default:          gauge_next = gauge_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gauge_reg <= '0;
        end else begin
            gauge_reg <= gauge_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        angle_reg  <= angle_next;
        step_reg   <= step_next;
        ax_mag_reg <= ax_mag_next;
        zero_reg   <= zero_next;
        tilt_reg   <= tilt_next;
    end

    assign m_gauge_percent = gauge_reg;

`include "accel_tilt_gauge_unit_assert.svh"

    `ATG_ASSERT_IMP(a_gauge_in_range, aclk, aresetn, 1'b1, gauge_reg <= atg_pkg::GAUGE_MAX)
    `ATG_ASSERT_NEXT(a_load_clears_step, aclk, aresetn, cmd.load, step_reg == '0)

endmodule

[src/atg_ctrl.sv]
// ---------------------------------------------------------------------------
// atg_ctrl
// Sequencer for the two CORDIC passes, mode register and result handshake.
// ---------------------------------------------------------------------------
module atg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_sample_valid,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_wdata,
    input  atg_pkg::dp_status_t status,
    output atg_pkg::dp_cmd_t    cmd
);

    atg_pkg::state_t     state_reg, state_next;
    atg_pkg::commit_op_t op_reg, op_next;
    logic                mode_reg, mode_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == atg_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        mode_next       = mode_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd             = '0;
        cmd.op          = op_reg;

        if (cfg_valid && cfg_ready) begin
            mode_next = cfg_wdata;
        end

        unique case (state_reg)
            atg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (mode_reg) begin
                        op_next    = atg_pkg::OP_DEMO;
                        state_next = atg_pkg::ST_COMMIT;
                    end else if (!s_sample_valid) begin
                        op_next    = atg_pkg::OP_HOLD;
                        state_next = atg_pkg::ST_COMMIT;
                    end else begin
                        op_next    = atg_pkg::OP_TILT;
                        state_next = atg_pkg::ST_PASS1;
                    end
                end
            end
            atg_pkg::ST_PASS1: begin
                cmd.step = 1'b1;
                if (status.step_last) begin
                    cmd.start_pass2 = 1'b1;
                    state_next      = atg_pkg::ST_PASS2;
                end
            end
            atg_pkg::ST_PASS2: begin
                cmd.step = 1'b1;
                if (status.step_last) begin
                    state_next = atg_pkg::ST_FINISH;
                end
            end
            atg_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = atg_pkg::ST_COMMIT;
            end
            atg_pkg::ST_COMMIT: begin
                // wait for the output slot to be empty or drained this cycle
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = atg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = atg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= atg_pkg::ST_IDLE;
            op_reg      <= atg_pkg::OP_HOLD;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

`include "accel_tilt_gauge_unit_assert.svh"

    `ATG_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg != atg_pkg::ST_IDLE)
    `ATG_ASSERT_IMP(a_commit_has_room, aclk, aresetn, cmd.commit, !m_valid_reg || m_ready)
    `ATG_ASSERT_NEXT(a_commit_sets_valid, aclk, aresetn, cmd.commit, m_valid_reg)

endmodule

[src/accel_tilt_gauge_unit.sv]
// ---------------------------------------------------------------------------
// accel_tilt_gauge_unit
// Tilt gauge from a three-axis accelerometer sample, or a demo ramp.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat (s_valid/s_ready): one tick with accel_x/y/z and sample_valid.
//   Output beat (m_valid/m_ready): the gauge in percent of 45 degrees, one
//   per input beat, in order.
//   Config (cfg_valid/cfg_ready/cfg_wdata): mode bit, 0 tilt, 1 demo ramp;
//   always ready; user must write it only while the unit is idle (unchecked).
// Timing:
//   A tilt beat with a valid sample runs two CORDIC vectoring passes on one
//   shared rotation stage, then a scaling step and a commit step. Demo and
//   invalid-sample beats go from the accept straight to the commit step.
//   s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous): gauge 0, mode tilt, output empty.
// Stall: a result waits in the output register; the next beat is accepted
//   and processed meanwhile, and holds at commit until the slot frees.
// ---------------------------------------------------------------------------
module accel_tilt_gauge_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_x,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_y,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_z,
    input  logic                                   s_sample_valid,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [atg_pkg::GAUGE_W-1:0]            m_gauge_percent,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_wdata
);

    atg_pkg::dp_cmd_t    cmd;
    atg_pkg::dp_status_t status;

    atg_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_valid (s_sample_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata),
        .status         (status),
        .cmd            (cmd)
    );

    atg_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_accel_x       (s_accel_x),
        .s_accel_y       (s_accel_y),
        .s_accel_z       (s_accel_z),
        .cmd             (cmd),
        .status          (status),
        .m_gauge_percent (m_gauge_percent)
    );

endmodule

[bench/atg_tb_pkg.sv]
// ---------------------------------------------------------------------------
// atg_tb_pkg
// Mode codes for the tilt gauge bench, shared by stimulus and checker.
// ---------------------------------------------------------------------------
package atg_tb_pkg;

    typedef enum logic {
        MODE_TILT = 1'b0,
        MODE_DEMO = 1'b1
    } gauge_mode_t;

endpackage

[bench/tilt_gauge_monitor.sv]
// ---------------------------------------------------------------------------
// tilt_gauge_monitor
// Watches the sample, gauge and mode channels of the tilt gauge unit, works
// out the gauge of every accepted beat with its own CORDIC model, demo ramp
// or held value; compares gauge beats in order, returns mismatch/pending counts.
// ---------------------------------------------------------------------------
module tilt_gauge_monitor (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_x,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_y,
    input  logic signed [atg_pkg::SAMPLE_BITS-1:0] s_accel_z,
    input  logic                                   s_sample_valid,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [atg_pkg::GAUGE_W-1:0]            m_gauge_percent,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic                                   cfg_wdata,
    output int                                     mismatch_count,
    output int                                     gauge_outstanding
);

    localparam int SHOWN_MISMATCHES = 10;

    // atan(2^-i) in degrees, Q16
    longint atan_deg_q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    atg_tb_pkg::gauge_mode_t     mode_r;
    logic [atg_pkg::GAUGE_W-1:0] gauge_r;
    logic [atg_pkg::GAUGE_W-1:0] gauge_due [$];

    // vectoring pass: drives y to zero, returns x, accumulated angle out
    function automatic longint cordic_vectoring(input longint x0, input longint y0,
                                                output longint angle);
        longint xv, yv, dx, dy, acc;
        int     i;
        xv  = x0;
        yv  = y0;
        acc = 0;
        for (i = 0; i < atg_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv  = xv + dx;
                yv  = yv - dy;
                acc = acc + atan_deg_q16[i];
            end else begin
                xv  = xv - dx;
                yv  = yv + dy;
                acc = acc - atan_deg_q16[i];
            end
        end
        angle = acc;
        return xv;
    endfunction

    function automatic logic [atg_pkg::GAUGE_W-1:0] tilt_to_percent(
        input logic signed [atg_pkg::SAMPLE_BITS-1:0] x,
        input logic signed [atg_pkg::SAMPLE_BITS-1:0] y,
        input logic signed [atg_pkg::SAMPLE_BITS-1:0] z
    );
        longint ax, ay, az, r, yin, ang, scratch, g;
        ax = x;
        ay = y;
        az = z;
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        if (az < 0) az = -az;
        if (ax == 0 && ay == 0 && az == 0)
            return '0;
        if (ay == 0 && az == 0)
            r = 0;
        else
            r = cordic_vectoring(ay << 16, az << 16, scratch);
        yin = ax * longint'(atg_pkg::GAIN_Q16);
        void'(cordic_vectoring(r, yin, ang));
        if (ang < 0)
            ang = 0;
        g = (ang * 20) / (9 * 65536);
        if (g > longint'(atg_pkg::GAUGE_MAX))
            g = longint'(atg_pkg::GAUGE_MAX);
        return atg_pkg::GAUGE_W'(g);
    endfunction

    always @(posedge aclk) begin
        logic [atg_pkg::GAUGE_W-1:0] want;
        int                          nxt;
        if (!aresetn) begin
            mode_r  = atg_tb_pkg::MODE_TILT;
            gauge_r = '0;
            gauge_due.delete();
            mismatch_count    <= 0;
            gauge_outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                mode_r = atg_tb_pkg::gauge_mode_t'(cfg_wdata);

            if (m_valid && m_ready) begin
                if (gauge_due.size() == 0) begin
                    if (mismatch_count < SHOWN_MISMATCHES)
                        $display("gauge beat with nothing outstanding: got %0d",
                                 m_gauge_percent);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = gauge_due.pop_front();
                    if (m_gauge_percent !== want) begin
                        if (mismatch_count < SHOWN_MISMATCHES)
                            $display("gauge mismatch: expected %0d, got %0d",
                                     want, m_gauge_percent);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (mode_r == atg_tb_pkg::MODE_DEMO) begin
                    nxt = int'(gauge_r) + int'(atg_pkg::DEMO_STEP);
                    if (nxt > int'(atg_pkg::GAUGE_MAX))
                        nxt = 0;
                    gauge_r = atg_pkg::GAUGE_W'(nxt);
                end else if (s_sample_valid) begin
                    gauge_r = tilt_to_percent(s_accel_x, s_accel_y, s_accel_z);
                end
                gauge_due.push_back(gauge_r);
            end

            gauge_outstanding <= gauge_due.size();
        end
    end

endmodule

[bench/accel_tilt_gauge_unit_test.sv]
// ---------------------------------------------------------------------------
// accel_tilt_gauge_unit_test
// Drives sample beats and mode writes into the tilt gauge unit with random
// gaps and receiver stalls, including two long output hold-offs; a monitor
// predicts and checks every gauge beat. Prints the verdict at the end.
// ---------------------------------------------------------------------------
module accel_tilt_gauge_unit_test;

    localparam int  SB          = atg_pkg::SAMPLE_BITS;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  IDLE_GUARD  = 40;
    localparam int  LONG_HOLD   = 800;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SB-1:0]          s_accel_x;
    logic signed [SB-1:0]          s_accel_y;
    logic signed [SB-1:0]          s_accel_z;
    logic                          s_sample_valid;
    logic                          m_valid;
    logic                          m_ready;
    logic [atg_pkg::GAUGE_W-1:0]   m_gauge_percent;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_wdata;

    int mismatch_count;
    int gauge_outstanding;
    int out_beats;
    int cycles;
    bit sender_steady;

    accel_tilt_gauge_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_accel_x       (s_accel_x),
        .s_accel_y       (s_accel_y),
        .s_accel_z       (s_accel_z),
        .s_sample_valid  (s_sample_valid),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_gauge_percent (m_gauge_percent),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata)
    );

    tilt_gauge_monitor i_monitor (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_accel_x         (s_accel_x),
        .s_accel_y         (s_accel_y),
        .s_accel_z         (s_accel_z),
        .s_sample_valid    (s_sample_valid),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_gauge_percent   (m_gauge_percent),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_wdata         (cfg_wdata),
        .mismatch_count    (mismatch_count),
        .gauge_outstanding (gauge_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            out_beats <= 0;
        else if (m_valid && m_ready)
            out_beats <= out_beats + 1;
    end

    // mostly short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [SB-1:0] draw_axis();
        int          w;
        logic [SB-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'hffff;
                    3:       v = 16'h0001;
                    default: v = 16'h0000;
                endcase
            end
            1, 2: v = SB'($urandom);
            default: begin
                w = $urandom_range(0, SB - 1);
                v = SB'($urandom) & SB'((32'd1 << w) - 1);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_tick(input logic signed [SB-1:0] x, input logic signed [SB-1:0] y,
                             input logic signed [SB-1:0] z, input logic sv);
        int gap;
        gap = sender_steady ? 0 : draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_accel_x      <= x;
        s_accel_y      <= y;
        s_accel_z      <= z;
        s_sample_valid <= sv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // mode writes only once every gauge beat is back and the unit has settled
    task automatic write_mode(input atg_tb_pkg::gauge_mode_t m);
        s_valid <= 1'b0;
        while (gauge_outstanding != 0) @(negedge aclk);
        repeat (IDLE_GUARD) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_tilt(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 64 == 0)
                sender_steady = ($urandom_range(0, 2) == 0);
            // mostly fresh samples, some stale ticks as noise
            send_tick(draw_axis(), draw_axis(), draw_axis(), $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic run_demo(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 64 == 0)
                sender_steady = ($urandom_range(0, 2) == 0);
            send_tick(SB'($urandom), SB'($urandom), SB'($urandom), 1'($urandom));
        end
    endtask

    // receiver: random stalls, steady stretches, two long hold-offs
    initial begin
        int stall_left;
        bit steady;
        int holds_done;
        stall_left = 0;
        steady     = 1'b0;
        holds_done = 0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0)
                steady = !steady;
            if ((holds_done == 0 && out_beats >= 150) ||
                (holds_done == 1 && out_beats >= 1000)) begin
                stall_left = LONG_HOLD;
                holds_done++;
            end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
                stall_left = draw_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_accel_x      = '0;
        s_accel_y      = '0;
        s_accel_z      = '0;
        s_sample_valid = 1'b0;
        cfg_valid      = 1'b0;
        cfg_wdata      = 1'b0;
        sender_steady  = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_mode(atg_tb_pkg::MODE_TILT);
        send_tick(0, 0, 0, 1'b1);                    // no acceleration at all
        send_tick(32767, 0, 0, 1'b1);                // pure x, saturates
        send_tick(0, 0, 0, 1'b0);                    // stale tick holds gauge
        send_tick(-32768, 0, 0, 1'b1);
        send_tick(0, 32767, -32768, 1'b1);           // flat
        send_tick(0, -32768, 0, 1'b1);
        send_tick(-32768, -32768, -32768, 1'b1);
        send_tick(32767, 32767, 32767, 1'b1);
        send_tick(1, 1, 0, 1'b1);
        send_tick(1, 0, 1, 1'b1);
        send_tick(100, 1000, 0, 1'b1);
        send_tick(16'sh5555, 16'shaaaa, 16'sh5555, 1'b1);
        send_tick(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b1);
        send_tick(-1, -1, -1, 1'b1);
        send_tick(32767, -32768, 32767, 1'b0);
        send_tick(300, 0, 1000, 1'b1);
        send_tick(1, 32767, 32767, 1'b1);
        send_tick(-1, 0, 0, 1'b1);

        write_mode(atg_tb_pkg::MODE_DEMO);
        send_tick(0, 0, 0, 1'b0);                    // wraps from full scale
        send_tick(32767, -32768, -1, 1'b1);
        send_tick(-32768, 32767, 0, 1'b0);
        send_tick(0, 0, 0, 1'b1);
        send_tick(16'sh5555, 16'shaaaa, 16'sh5555, 1'b1);
        send_tick(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0);

        write_mode(atg_tb_pkg::MODE_DEMO);
        run_demo(40);
        write_mode(atg_tb_pkg::MODE_TILT);
        run_tilt(600);
        write_mode(atg_tb_pkg::MODE_DEMO);
        run_demo(220);
        write_mode(atg_tb_pkg::MODE_TILT);
        run_tilt(560);
        write_mode(atg_tb_pkg::MODE_DEMO);
        run_demo(260);

        s_valid <= 1'b0;
        while (gauge_outstanding != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (mismatch_count == 0 && gauge_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[accel_tilt_gauge_unit.f]
+incdir+src
src/atg_pkg.sv
src/atg_datapath.sv
src/atg_ctrl.sv
src/accel_tilt_gauge_unit.sv
bench/atg_tb_pkg.sv
bench/tilt_gauge_monitor.sv
bench/accel_tilt_gauge_unit_test.sv
